>>> rtl/tse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tse_pkg;
    localparam int MAX_TERMS_DEF = 10;
    localparam int FRAC_BITS_DEF = 28;
    localparam int DATA_W = 32;
    localparam int CNT_W = 4;

    localparam logic [1:0] FUNC_SIN = 2'd0;
    localparam logic [1:0] FUNC_COS = 2'd1;
    localparam logic [1:0] FUNC_LN1P = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] x_value;
        logic [3:0]         term_count;
    } t_req_in;

    typedef struct packed {
        logic signed [31:0] series_sum;
        logic               saturated;
    } t_req_out;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_X2,
        OP_MUL_TX2,
        OP_MUL_TX,
        OP_DIV,
        OP_NEG,
        OP_ADD
    } t_op;

    typedef struct packed {
        logic       go;
        t_op        op;
        logic [4:0] k;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_sts;

    // reciprocal round(2^32/k), k = 1..20
    function automatic logic [32:0] recip(input logic [4:0] k);
        logic [32:0] r;
        begin
            case (k)
                5'd1: r = 33'h100000000;
                5'd2: r = 33'd2147483648;
                5'd3: r = 33'd1431655765;
                5'd4: r = 33'd1073741824;
                5'd5: r = 33'd858993459;
                5'd6: r = 33'd715827883;
                5'd7: r = 33'd613566757;
                5'd8: r = 33'd536870912;
                5'd9: r = 33'd477218588;
                5'd10: r = 33'd429496730;
                5'd11: r = 33'd390451572;
                5'd12: r = 33'd357913941;
                5'd13: r = 33'd330382100;
                5'd14: r = 33'd306783378;
                5'd15: r = 33'd286331153;
                5'd16: r = 33'd268435456;
                5'd17: r = 33'd252645135;
                5'd18: r = 33'd238609294;
                5'd19: r = 33'd226050910;
                5'd20: r = 33'd214748365;
                default: r = 33'h100000000;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

>>> rtl/tse_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module tse_datapath import tse_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire t_req_in            i_req,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    output logic signed [31:0]      o_sum,
    output logic                    o_sat
);
    localparam logic signed [65:0] SMAX = 66'sd2147483647;
    localparam logic signed [65:0] SMIN = -66'sd2147483648;
    localparam logic [63:0] ONE_F = 64'd1 << FRAC_BITS;

    logic signed [31:0] r_x, r_x2, r_t, r_p, r_sum;
    logic               r_sat, r_done;
    logic [1:0]         r_ph;
    logic [31:0]        r_ma;
    logic [32:0]        r_mb;
    logic               r_neg;
    logic [64:0]        r_prod;

    logic signed [31:0] a, b;
    logic [31:0]        ma;
    logic [32:0]        mb;
    logic [64:0]        rnd;
    logic signed [65:0] sres, one_c;
    logic signed [32:0] ssum;
    logic signed [31:0] mres;
    logic               mclip;

    always_comb begin
        a = r_t;
        b = r_x;
        case (i_cmd.op)
            OP_X2: begin a = r_x; b = r_x; end
            OP_MUL_TX2: b = r_x2;
            OP_MUL_TX: a = r_p;
            default: ;
        endcase
        ma = a[31] ? 32'(-a) : 32'(a);
        mb = b[31] ? {1'b0, 32'(-b)} : {1'b0, b};
        if (i_cmd.op == OP_DIV) mb = recip(i_cmd.k);
        if (i_cmd.op == OP_DIV)
            rnd = (r_prod + (65'd1 << 31)) >> 32;
        else
            rnd = (r_prod + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        sres = r_neg ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
        if (sres > SMAX) begin
            mres = 32'(SMAX);
            mclip = 1'b1;
        end else if (sres < SMIN) begin
            mres = 32'(SMIN);
            mclip = 1'b1;
        end else begin
            mres = 32'(sres);
            mclip = 1'b0;
        end
        one_c = $signed({2'b0, ONE_F});
        ssum = 33'(r_sum) + 33'(r_t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_x <= i_req.x_value;
                r_p <= i_req.x_value;
                r_sum <= '0;
                r_sat <= 1'b0;
                r_ph <= '0;
                if (i_req.func == FUNC_COS) begin
                    if (one_c > SMAX) begin r_t <= 32'(SMAX); r_sat <= 1'b1; end
                    else r_t <= 32'(one_c);
                end else r_t <= i_req.x_value;
            end else if (i_cmd.go) begin
                case (i_cmd.op)
                    OP_NEG: begin
                        if (r_t == 32'sh80000000) begin
                            r_t <= 32'(SMAX); r_sat <= 1'b1;
                        end else r_t <= -r_t;
                        r_done <= 1'b1;
                    end
                    OP_ADD: begin
                        if (ssum > 33'sd2147483647) begin
                            r_sum <= 32'(SMAX); r_sat <= 1'b1;
                        end else if (ssum < -33'sd2147483648) begin
                            r_sum <= 32'(SMIN); r_sat <= 1'b1;
                        end else r_sum <= 32'(ssum);
                        r_done <= 1'b1;
                    end
                    default: begin
                        case (r_ph)
                            2'd0: begin
                                r_ma <= ma; r_mb <= mb;
                                r_neg <= (i_cmd.op == OP_DIV) ? a[31] : (a[31] ^ b[31]);
                                r_ph <= 2'd1;
                            end
                            2'd1: begin
                                r_prod <= 65'(r_ma) * 65'(r_mb);
                                r_ph <= 2'd2;
                            end
                            default: begin
                                r_ph <= '0;
                                r_done <= 1'b1;
                                if (i_cmd.op == OP_DIV) r_t <= 32'(sres);
                                else begin
                                    if (mclip) r_sat <= 1'b1;
                                    if (i_cmd.op == OP_X2) r_x2 <= mres;
                                    else r_t <= mres;
                                    // ln(1+x) keeps the running power apart
                                    if (i_cmd.op == OP_MUL_TX) r_p <= mres;
                                end
                            end
                        endcase
                    end
                endcase
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_sum = r_sum;
    assign o_sat = r_sat;
endmodule
`default_nettype wire

>>> rtl/tse_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tse_ctrl import tse_pkg::*; #(
    parameter int MAX_TERMS = MAX_TERMS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_req_in i_req,
    output logic         o_load,
    output t_cmd         o_cmd,
    input  wire t_sts    i_sts,
    input  wire logic signed [31:0] i_sum,
    input  wire logic    i_sat,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_req_out     o_out
);
    typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} t_state;
    t_state      r_state;
    logic [1:0]  r_func;
    logic [3:0]  r_n, r_i;
    logic [2:0]  r_step;
    logic        r_zero;
    t_cmd        cmd;
    logic [3:0]  n_lim;
    logic        last_step;

    always_comb begin
        n_lim = (i_req.term_count > 4'(MAX_TERMS)) ? 4'(MAX_TERMS) : i_req.term_count;
        // hold off for the cycle in which the previous step reports done
        cmd.go = (r_state == S_RUN) && !i_sts.done;
        cmd.k = '0;
        cmd.op = OP_ADD;
        last_step = 1'b0;
        if (r_func == FUNC_LN1P) begin
            // i counts 1..n; steps: mul (i>1), div i, neg (even), add
            case (r_step)
                3'd0: cmd.op = OP_MUL_TX;
                3'd1: begin cmd.op = OP_DIV; cmd.k = {1'b0, r_i}; end
                3'd2: cmd.op = OP_NEG;
                default: begin cmd.op = OP_ADD; last_step = 1'b1; end
            endcase
        end else begin
            case (r_step)
                3'd0: cmd.op = OP_X2;
                3'd1: cmd.op = OP_MUL_TX2;
                3'd2: begin
                    cmd.op = OP_DIV;
                    cmd.k = (r_func == FUNC_SIN) ? 5'({r_i, 1'b0}) : 5'({r_i, 1'b0} - 5'd1);
                end
                3'd3: begin
                    cmd.op = OP_DIV;
                    cmd.k = (r_func == FUNC_SIN) ? 5'({r_i, 1'b0} + 5'd1) : 5'({r_i, 1'b0});
                end
                3'd4: cmd.op = OP_NEG;
                default: begin cmd.op = OP_ADD; last_step = 1'b1; end
            endcase
        end
    end

    function automatic logic [2:0] first_step(input logic [1:0] f, input logic [3:0] i);
        logic [2:0] s;
        begin
            if (f == FUNC_LN1P) s = (i == 4'd1) ? 3'd1 : 3'd0;
            else if (i == 4'd0) s = 3'd5;
            else if (i == 4'd1) s = 3'd0;
            else s = 3'd1;
            return s;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_func <= i_req.func;
                    r_n <= n_lim;
                    r_zero <= (n_lim == 4'd0) || (i_req.func == FUNC_UNUSED);
                    r_i <= (i_req.func == FUNC_LN1P) ? 4'd1 : 4'd0;
                    r_step <= first_step(i_req.func, (i_req.func == FUNC_LN1P) ? 4'd1 : 4'd0);
                    r_state <= ((n_lim == 4'd0) || (i_req.func == FUNC_UNUSED)) ? S_OUT : S_RUN;
                    if ((n_lim == 4'd0) || (i_req.func == FUNC_UNUSED)) o_out_valid <= 1'b1;
                end
                S_RUN: if (i_sts.done) begin
                    if (last_step) begin
                        if ((r_func == FUNC_LN1P) ? (r_i == r_n) : (r_i + 4'd1 == r_n)) begin
                            r_state <= S_OUT;
                            o_out_valid <= 1'b1;
                        end else begin
                            r_i <= r_i + 4'd1;
                            r_step <= first_step(r_func, r_i + 4'd1);
                        end
                    end else if (r_func == FUNC_LN1P && r_step == 3'd1 && !r_i[0])
                        r_step <= 3'd2;
                    else if (r_func == FUNC_LN1P && r_step == 3'd1)
                        r_step <= 3'd3;
                    else if (r_func != FUNC_LN1P && r_step == 3'd0 && r_i == 4'd0)
                        r_step <= 3'd5;
                    else
                        r_step <= r_step + 3'd1;
                end
                S_OUT: if (!i_out_stall) begin
                    o_out_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_load = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd = cmd;
    assign o_out.series_sum = r_zero ? 32'sd0 : i_sum;
    assign o_out.saturated = r_zero ? 1'b0 : i_sat;
endmodule
`default_nettype wire

>>> rtl/taylor_series_evaluator.sv
// channel | signals                          | payload
// in      | i_in_valid / o_in_stall          | i_in  (t_req_in)
// out     | o_out_valid / i_out_stall        | o_out (t_req_out)
// One request at a time on the shared 33x32 multiplier: a multiply or divide steps through
// operand, product and rounding phases, while a negate or an add completes directly.
// Zero terms or unused operation: result valid the cycle after accept.
// Reset is synchronous, active low; clears the controller.
// A stalled result holds; no new request is taken until it leaves.
`timescale 1ns / 1ps
`default_nettype none
module taylor_series_evaluator import tse_pkg::*; #(
    parameter int MAX_TERMS = MAX_TERMS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_req_in i_in,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_req_out     o_out
);
    logic load;
    t_cmd cmd;
    t_sts sts;
    logic signed [31:0] sum;
    logic sat;

    tse_ctrl #(.MAX_TERMS(MAX_TERMS)) u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_req(i_in),
        .o_load(load), .o_cmd(cmd), .i_sts(sts), .i_sum(sum), .i_sat(sat),
        .o_out_valid, .i_out_stall, .o_out
    );

    tse_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_load(load), .i_req(i_in), .i_cmd(cmd),
        .o_sts(sts), .o_sum(sum), .o_sat(sat)
    );
endmodule
`default_nettype wire

>>> rtl/tse_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module tse_props import tse_pkg::*; (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_in_valid,
    input wire logic     o_in_stall,
    input wire logic     o_out_valid,
    input wire logic     i_out_stall,
    input wire t_req_out o_out
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("request taken with result pending");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("accepted request did not occupy block");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
endmodule

bind taylor_series_evaluator tse_props u_chk (
    .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .o_out_valid, .i_out_stall, .o_out
);
`default_nettype wire
